// ----- rtl/core/owts_pkg.sv -----
package owts_pkg;

  // Sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_R1_LOW  = 5'd1,
    PH_R1_WAIT = 5'd2,
    PH_R1_REC  = 5'd3,
    PH_W1_LOW  = 5'd4,
    PH_W1_REL  = 5'd5,
    PH_CONV    = 5'd6,
    PH_R2_LOW  = 5'd7,
    PH_R2_WAIT = 5'd8,
    PH_R2_REC  = 5'd9,
    PH_W2_LOW  = 5'd10,
    PH_W2_REL  = 5'd11,
    PH_RD_LOW  = 5'd12,
    PH_RD_WAIT = 5'd13,
    PH_RD_REC  = 5'd14
  } phase_t;

  localparam int unsigned TMR_W = 20;

  // Bus commands
  localparam logic [7:0] CMD_SKIP = 8'hCC;
  localparam logic [7:0] CMD_CONV = 8'h44;
  localparam logic [7:0] CMD_READ = 8'hBE;

  // Slot timing in microseconds
  localparam logic [TMR_W-1:0] T_RST_LOW   = 20'd480;
  localparam logic [TMR_W-1:0] T_PRES      = 20'd70;
  localparam logic [TMR_W-1:0] T_RST_REC   = 20'd410;
  localparam logic [TMR_W-1:0] T_W1_LOW    = 20'd6;
  localparam logic [TMR_W-1:0] T_W1_REL    = 20'd64;
  localparam logic [TMR_W-1:0] T_W0_LOW    = 20'd60;
  localparam logic [TMR_W-1:0] T_W0_REL    = 20'd10;
  localparam logic [TMR_W-1:0] T_RD_LOW    = 20'd6;
  localparam logic [TMR_W-1:0] T_RD_SAMPLE = 20'd9;
  localparam logic [TMR_W-1:0] T_RD_REC    = 20'd55;

  localparam logic [TMR_W-1:0] CONV_WAIT_RST = 20'd750000;

endpackage

// ----- rtl/core/onewire_temp_read_sequencer_unit.sv -----
// Each item passes through the input register and then the output register.
// Throughput: one input item per cycle; the input register and the output register
// each advance whenever the stage after them can take data.
// Reset (rst_n low, synchronous): both stages empty, sequencer idle, all counters
// and shift registers cleared, conversion wait set to 750000 us.
module onewire_temp_read_sequencer_unit (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [19:0]        cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_start_req,
  input  logic               in_tick_us,
  input  logic               in_line_level,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_drive_low,
  output logic               out_busy_res,
  output logic               out_done_res,
  output logic               out_status,
  output logic signed [15:0] out_temperature_raw
);

  // Configuration register
  logic [owts_pkg::TMR_W-1:0] conv_wait_r;

  // Input stage
  logic s1_valid_r;
  logic s1_start_r, s1_tick_r, s1_line_r;

  // Sequencer state
  owts_pkg::phase_t           phase_r, phase_nxt;
  logic [owts_pkg::TMR_W-1:0] slot_timer_r, slot_timer_nxt;
  logic [2:0]                 bit_cnt_r, bit_cnt_nxt;
  logic                       byte_cnt_r, byte_cnt_nxt;
  logic [7:0]                 shift_r, shift_nxt;
  logic [15:0]                reading_r, reading_nxt;
  logic                       err_r, err_nxt;
  logic                       done_nxt;

  // Output stage
  logic        out_valid_r;
  logic        drive_low_r, busy_r, done_r, status_r;
  logic [15:0] temp_r;

  // Computed results
  logic        drive_low_c, busy_c, status_c;
  logic [15:0] temp_c;

  // Timer helpers
  logic [owts_pkg::TMR_W-1:0] dur;
  logic [owts_pkg::TMR_W:0]   tmr_inc;
  logic                       tmr_hit;
  logic                       bitv;

  // Handshake
  logic out_load, adv, in_xfer;

  assign out_load = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_xfer  = in_valid && !in_stall;

  assign bitv = shift_r[0];

  // Interval length for the current phase
  always_comb begin
    case (phase_r)
      owts_pkg::PH_R1_LOW, owts_pkg::PH_R2_LOW:   dur = owts_pkg::T_RST_LOW;
      owts_pkg::PH_R1_WAIT, owts_pkg::PH_R2_WAIT: dur = owts_pkg::T_PRES;
      owts_pkg::PH_R1_REC, owts_pkg::PH_R2_REC:   dur = owts_pkg::T_RST_REC;
      owts_pkg::PH_W1_LOW, owts_pkg::PH_W2_LOW:
        dur = bitv ? owts_pkg::T_W1_LOW : owts_pkg::T_W0_LOW;
      owts_pkg::PH_W1_REL, owts_pkg::PH_W2_REL:
        dur = bitv ? owts_pkg::T_W1_REL : owts_pkg::T_W0_REL;
      owts_pkg::PH_CONV:    dur = conv_wait_r;
      owts_pkg::PH_RD_LOW:  dur = owts_pkg::T_RD_LOW;
      owts_pkg::PH_RD_WAIT: dur = owts_pkg::T_RD_SAMPLE;
      owts_pkg::PH_RD_REC:  dur = owts_pkg::T_RD_REC;
      default:              dur = owts_pkg::T_RST_LOW;
    endcase
  end

  // Tick counting: the interval ends on the tick that reaches its length
  assign tmr_inc = {1'b0, slot_timer_r} + {{owts_pkg::TMR_W{1'b0}}, 1'b1};
  assign tmr_hit = s1_tick_r && (tmr_inc >= {1'b0, dur});

  // Next state
  always_comb begin
    phase_nxt      = phase_r;
    slot_timer_nxt = slot_timer_r;
    bit_cnt_nxt    = bit_cnt_r;
    byte_cnt_nxt   = byte_cnt_r;
    shift_nxt      = shift_r;
    reading_nxt    = reading_r;
    err_nxt        = err_r;
    done_nxt       = 1'b0;

    // timer advance, shared by every timed phase
    if (phase_r != owts_pkg::PH_IDLE && s1_tick_r) begin
      slot_timer_nxt = tmr_hit ? '0 : tmr_inc[owts_pkg::TMR_W-1:0];
    end

    case (phase_r)
      owts_pkg::PH_R1_LOW: begin
        if (tmr_hit) phase_nxt = owts_pkg::PH_R1_WAIT;
      end
      owts_pkg::PH_R2_LOW: begin
        if (tmr_hit) phase_nxt = owts_pkg::PH_R2_WAIT;
      end
      owts_pkg::PH_R1_WAIT, owts_pkg::PH_R2_WAIT: begin
        if (tmr_hit) begin
          if (s1_line_r) begin
            // no presence pulse: abort with error
            err_nxt   = 1'b1;
            phase_nxt = owts_pkg::PH_IDLE;
            done_nxt  = 1'b1;
          end else begin
            phase_nxt = (phase_r == owts_pkg::PH_R1_WAIT) ? owts_pkg::PH_R1_REC
                                                          : owts_pkg::PH_R2_REC;
          end
        end
      end
      owts_pkg::PH_R1_REC, owts_pkg::PH_R2_REC: begin
        if (tmr_hit) begin
          phase_nxt    = (phase_r == owts_pkg::PH_R1_REC) ? owts_pkg::PH_W1_LOW
                                                          : owts_pkg::PH_W2_LOW;
          shift_nxt    = owts_pkg::CMD_SKIP;
          bit_cnt_nxt  = '0;
          byte_cnt_nxt = 1'b0;
        end
      end
      owts_pkg::PH_W1_LOW: begin
        if (tmr_hit) phase_nxt = owts_pkg::PH_W1_REL;
      end
      owts_pkg::PH_W2_LOW: begin
        if (tmr_hit) phase_nxt = owts_pkg::PH_W2_REL;
      end
      owts_pkg::PH_W1_REL, owts_pkg::PH_W2_REL: begin
        if (tmr_hit) begin
          shift_nxt = {1'b0, shift_r[7:1]};
          if (bit_cnt_r == 3'd7) begin
            bit_cnt_nxt = '0;
            if (!byte_cnt_r) begin
              // second command byte
              byte_cnt_nxt = 1'b1;
              if (phase_r == owts_pkg::PH_W1_REL) begin
                shift_nxt = owts_pkg::CMD_CONV;
                phase_nxt = owts_pkg::PH_W1_LOW;
              end else begin
                shift_nxt = owts_pkg::CMD_READ;
                phase_nxt = owts_pkg::PH_W2_LOW;
              end
            end else begin
              byte_cnt_nxt = 1'b0;
              shift_nxt    = '0;
              phase_nxt    = (phase_r == owts_pkg::PH_W1_REL) ? owts_pkg::PH_CONV
                                                              : owts_pkg::PH_RD_LOW;
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
            phase_nxt   = (phase_r == owts_pkg::PH_W1_REL) ? owts_pkg::PH_W1_LOW
                                                           : owts_pkg::PH_W2_LOW;
          end
        end
      end
      owts_pkg::PH_CONV: begin
        if (tmr_hit) phase_nxt = owts_pkg::PH_R2_LOW;
      end
      owts_pkg::PH_RD_LOW: begin
        if (tmr_hit) phase_nxt = owts_pkg::PH_RD_WAIT;
      end
      owts_pkg::PH_RD_WAIT: begin
        // sample the line, LSB first
        if (tmr_hit) begin
          shift_nxt = {s1_line_r, shift_r[7:1]};
          phase_nxt = owts_pkg::PH_RD_REC;
        end
      end
      owts_pkg::PH_RD_REC: begin
        if (tmr_hit) begin
          phase_nxt = owts_pkg::PH_RD_LOW;
          if (bit_cnt_r == 3'd7) begin
            bit_cnt_nxt = '0;
            if (!byte_cnt_r) begin
              reading_nxt  = {reading_r[15:8], shift_r};
              byte_cnt_nxt = 1'b1;
              shift_nxt    = '0;
            end else begin
              reading_nxt  = {shift_r, reading_r[7:0]};
              byte_cnt_nxt = 1'b0;
              err_nxt      = 1'b0;
              phase_nxt    = owts_pkg::PH_IDLE;
              done_nxt     = 1'b1;
            end
          end else begin
            bit_cnt_nxt = bit_cnt_r + 3'd1;
          end
        end
      end
      default: begin
        // idle: a start request launches the first reset pulse
        phase_nxt = owts_pkg::PH_IDLE;
        if (s1_start_r) begin
          phase_nxt      = owts_pkg::PH_R1_LOW;
          slot_timer_nxt = '0;
          bit_cnt_nxt    = '0;
          byte_cnt_nxt   = 1'b0;
          shift_nxt      = '0;
          err_nxt        = 1'b0;
        end
      end
    endcase
  end

  // Result fields from the updated state
  always_comb begin
    drive_low_c = (phase_nxt == owts_pkg::PH_R1_LOW) || (phase_nxt == owts_pkg::PH_R2_LOW) ||
                  (phase_nxt == owts_pkg::PH_W1_LOW) || (phase_nxt == owts_pkg::PH_W2_LOW) ||
                  (phase_nxt == owts_pkg::PH_RD_LOW);
    busy_c      = (phase_nxt != owts_pkg::PH_IDLE);
    status_c    = done_nxt && err_nxt;
    temp_c      = (done_nxt && !err_nxt) ? reading_nxt : 16'd0;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_wait_r <= owts_pkg::CONV_WAIT_RST;
    end else if (cfg_wr_en) begin
      conv_wait_r <= cfg_wr_data;
    end
  end

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_start_r <= in_start_req;
      s1_tick_r  <= in_tick_us;
      s1_line_r  <= in_line_level;
    end
  end

  // Sequencer state, updated as each item moves to the output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= owts_pkg::PH_IDLE;
      slot_timer_r <= '0;
      bit_cnt_r    <= '0;
      byte_cnt_r   <= 1'b0;
      shift_r      <= '0;
      reading_r    <= '0;
      err_r        <= 1'b0;
    end else if (adv) begin
      phase_r      <= phase_nxt;
      slot_timer_r <= slot_timer_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      byte_cnt_r   <= byte_cnt_nxt;
      shift_r      <= shift_nxt;
      reading_r    <= reading_nxt;
      err_r        <= err_nxt;
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_low_r <= drive_low_c;
      busy_r      <= busy_c;
      done_r      <= done_nxt;
      status_r    <= status_c;
      temp_r      <= temp_c;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_drive_low       = drive_low_r;
  assign out_busy_res        = busy_r;
  assign out_done_res        = done_r;
  assign out_status          = status_r;
  assign out_temperature_raw = signed'(temp_r);

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  // Cycles with no transfer on either channel before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  // Input items sent in each pacing phase
  localparam int PHASE_ITEMS = 225;

  typedef struct {
    bit start;
    bit tick;
    bit line;
  } line_item_t;

  typedef struct {
    bit                 drive_low;
    bit                 busy;
    bit                 done;
    bit                 status;
    logic signed [15:0] temp;
  } bus_result_t;

  typedef struct {
    owts_pkg::phase_t phase;
    logic [19:0]      timer;
    logic [2:0]       bitn;
    logic [1:0]       byten;
    logic [7:0]       shreg;
    logic [15:0]      reading;
    bit               err;
    logic [19:0]      conv_wait;
  } sequencer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [19:0]        cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_start_req = 1'b0;
  logic               in_tick_us = 1'b0;
  logic               in_line_level = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_drive_low;
  logic               out_busy_res;
  logic               out_done_res;
  logic               out_status;
  logic signed [15:0] out_temperature_raw;

  // Stimulus and scoreboard
  line_item_t  pending_items[$];
  bus_result_t expected_outputs[$];
  sequencer_t  gen_state;
  sequencer_t  chk_state;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_results = 0;
  int          n_reads_ok = 0;
  int          n_no_presence = 0;
  int          n_starts = 0;
  int          errs = 0;
  int          quiet = 0;
  bit          pres_now = 1'b0;
  bit          in_took = 1'b0;

  onewire_temp_read_sequencer_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_start_req        (in_start_req),
    .in_tick_us          (in_tick_us),
    .in_line_level       (in_line_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_drive_low       (out_drive_low),
    .out_busy_res        (out_busy_res),
    .out_done_res        (out_done_res),
    .out_status          (out_status),
    .out_temperature_raw (out_temperature_raw)
  );

  always #5 clk = ~clk;

  function automatic sequencer_t sequencer_reset();
    sequencer_t s;
    s.phase     = owts_pkg::PH_IDLE;
    s.timer     = '0;
    s.bitn      = '0;
    s.byten     = '0;
    s.shreg     = '0;
    s.reading   = '0;
    s.err       = 1'b0;
    s.conv_wait = owts_pkg::CONV_WAIT_RST;
    return s;
  endfunction

  // One microsecond tick toward dur; true on the tick that completes it
  function automatic bit interval_end(input bit tick, input logic [19:0] cur,
                                      input logic [19:0] dur, output logic [19:0] nxt);
    logic [20:0] t;
    nxt = cur;
    if (!tick) return 1'b0;
    t = {1'b0, cur} + 21'd1;
    if (t >= {1'b0, dur}) begin
      nxt = '0;
      return 1'b1;
    end
    nxt = t[19:0];
    return 1'b0;
  endfunction

  // Advance the read sequencer by one input item and form the bus outputs
  function automatic void advance_sequencer(inout sequencer_t s, input line_item_t it,
                                            output bus_result_t r);
    bit done;
    bit bitv;
    done = 1'b0;
    bitv = s.shreg[0];
    case (s.phase)
      owts_pkg::PH_R1_LOW, owts_pkg::PH_R2_LOW: begin
        if (interval_end(it.tick, s.timer, owts_pkg::T_RST_LOW, s.timer))
          s.phase = owts_pkg::phase_t'(s.phase + 5'd1);
      end
      owts_pkg::PH_R1_WAIT, owts_pkg::PH_R2_WAIT: begin
        if (interval_end(it.tick, s.timer, owts_pkg::T_PRES, s.timer)) begin
          if (it.line) begin
            // no device answered the reset pulse
            s.err   = 1'b1;
            s.phase = owts_pkg::PH_IDLE;
            done    = 1'b1;
          end else begin
            s.phase = owts_pkg::phase_t'(s.phase + 5'd1);
          end
        end
      end
      owts_pkg::PH_R1_REC, owts_pkg::PH_R2_REC: begin
        if (interval_end(it.tick, s.timer, owts_pkg::T_RST_REC, s.timer)) begin
          s.phase = (s.phase == owts_pkg::PH_R1_REC) ? owts_pkg::PH_W1_LOW
                                                     : owts_pkg::PH_W2_LOW;
          s.shreg = owts_pkg::CMD_SKIP;
          s.bitn  = '0;
          s.byten = '0;
        end
      end
      owts_pkg::PH_W1_LOW, owts_pkg::PH_W2_LOW: begin
        if (interval_end(it.tick, s.timer, bitv ? owts_pkg::T_W1_LOW : owts_pkg::T_W0_LOW,
                         s.timer))
          s.phase = owts_pkg::phase_t'(s.phase + 5'd1);
      end
      owts_pkg::PH_W1_REL, owts_pkg::PH_W2_REL: begin
        if (interval_end(it.tick, s.timer, bitv ? owts_pkg::T_W1_REL : owts_pkg::T_W0_REL,
                         s.timer)) begin
          s.shreg = s.shreg >> 1;
          if (s.bitn == 3'd7) begin
            s.bitn = '0;
            if (s.byten == 2'd0) begin
              // skip-ROM sent, follow with the function command
              s.byten = 2'd1;
              s.shreg = (s.phase == owts_pkg::PH_W1_REL) ? owts_pkg::CMD_CONV
                                                         : owts_pkg::CMD_READ;
              s.phase = owts_pkg::phase_t'(s.phase - 5'd1);
            end else begin
              s.byten = '0;
              s.shreg = '0;
              s.phase = (s.phase == owts_pkg::PH_W1_REL) ? owts_pkg::PH_CONV
                                                         : owts_pkg::PH_RD_LOW;
            end
          end else begin
            s.bitn  = s.bitn + 3'd1;
            s.phase = owts_pkg::phase_t'(s.phase - 5'd1);
          end
        end
      end
      owts_pkg::PH_CONV: begin
        if (interval_end(it.tick, s.timer, s.conv_wait, s.timer))
          s.phase = owts_pkg::PH_R2_LOW;
      end
      owts_pkg::PH_RD_LOW: begin
        if (interval_end(it.tick, s.timer, owts_pkg::T_RD_LOW, s.timer))
          s.phase = owts_pkg::PH_RD_WAIT;
      end
      owts_pkg::PH_RD_WAIT: begin
        if (interval_end(it.tick, s.timer, owts_pkg::T_RD_SAMPLE, s.timer)) begin
          s.shreg = {it.line, s.shreg[7:1]};
          s.phase = owts_pkg::PH_RD_REC;
        end
      end
      owts_pkg::PH_RD_REC: begin
        if (interval_end(it.tick, s.timer, owts_pkg::T_RD_REC, s.timer)) begin
          if (s.bitn == 3'd7) begin
            s.bitn = '0;
            if (s.byten == 2'd0) begin
              // first byte on the wire is the low byte
              s.reading[7:0] = s.shreg;
              s.byten        = 2'd1;
              s.shreg        = '0;
              s.phase        = owts_pkg::PH_RD_LOW;
            end else begin
              s.reading[15:8] = s.shreg;
              s.byten         = '0;
              s.err           = 1'b0;
              s.phase         = owts_pkg::PH_IDLE;
              done            = 1'b1;
            end
          end else begin
            s.bitn  = s.bitn + 3'd1;
            s.phase = owts_pkg::PH_RD_LOW;
          end
        end
      end
      default: begin
        // idle, and any stray code: a start opens the first reset
        s.phase = owts_pkg::PH_IDLE;
        if (it.start) begin
          s.phase = owts_pkg::PH_R1_LOW;
          s.timer = '0;
          s.bitn  = '0;
          s.byten = '0;
          s.shreg = '0;
          s.err   = 1'b0;
        end
      end
    endcase
    r.drive_low = s.phase inside {owts_pkg::PH_R1_LOW, owts_pkg::PH_R2_LOW,
                                  owts_pkg::PH_W1_LOW, owts_pkg::PH_W2_LOW,
                                  owts_pkg::PH_RD_LOW};
    r.busy      = (s.phase != owts_pkg::PH_IDLE);
    r.done      = done;
    r.status    = done && s.err;
    r.temp      = (done && !s.err) ? s.reading : 16'sd0;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errs++;
    end
  endfunction

  // Step the stimulus-side copy so line levels can be steered, then queue the item
  task automatic enqueue(input line_item_t it);
    bus_result_t unused;
    advance_sequencer(gen_state, it, unused);
    pending_items.push_back(it);
    n_queued++;
  endtask

  // Extend the stimulus stream: start requests (acted on only from idle), random ticks
  // and line levels, with the presence answer chosen once per run
  task automatic queue_stream(input int n);
    line_item_t it;
    repeat (n) begin
      if (gen_state.phase == owts_pkg::PH_IDLE) begin
        it.start = ($urandom_range(0, 7) == 0);
        if (it.start) begin
          // first run finds no device, later ones may get an answer
          pres_now = (n_starts != 0) && ($urandom_range(0, 1) == 1);
          n_starts++;
        end
      end else begin
        it.start = ($urandom_range(0, 15) == 0);
      end
      it.tick = ($urandom_range(0, 9) != 0);
      it.line = 1'($urandom_range(0, 1));
      if (it.tick && (gen_state.phase == owts_pkg::PH_R1_WAIT ||
                      gen_state.phase == owts_pkg::PH_R2_WAIT))
        it.line = !pres_now;
      enqueue(it);
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (n_accepted != n_queued || expected_outputs.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input bit write_cfg, input logic [19:0] wait_us, input int gap,
                           input int stall, input int n_items);
    if (write_cfg) begin
      @(negedge clk);
      cfg_wr_data <= wait_us;
      cfg_wr_en   <= 1'b1;
      @(negedge clk);
      cfg_wr_en   <= 1'b0;
      repeat (2) @(negedge clk);
    end
    gen_state.conv_wait = wait_us;
    @(posedge clk);
    send_gap_pct   = gap;
    recv_stall_pct = stall;
    queue_stream(n_items);
    drain();
  endtask

  // Driver: present the next item once the previous one transferred
  always @(negedge clk) begin
    line_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        nxt           = pending_items.pop_front();
        in_valid      <= 1'b1;
        in_start_req  <= nxt.start;
        in_tick_us    <= nxt.tick;
        in_line_level <= nxt.line;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Monitor: predict on each input transfer, check each result transfer
  always @(posedge clk) begin
    line_item_t  it;
    bus_result_t r;
    bus_result_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      if (cfg_wr_en)
        chk_state.conv_wait = cfg_wr_data;
      if (in_valid && !in_stall) begin
        it.start = in_start_req;
        it.tick  = in_tick_us;
        it.line  = in_line_level;
        advance_sequencer(chk_state, it, r);
        expected_outputs.push_back(r);
        n_accepted++;
      end
      in_took <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_outputs.size() == 0) begin
          $error("result transfer with no expected result pending");
          errs++;
        end else begin
          want = expected_outputs.pop_front();
          check_field("drive_low", 16'(want.drive_low), 16'(out_drive_low));
          check_field("busy_res", 16'(want.busy), 16'(out_busy_res));
          check_field("done_res", 16'(want.done), 16'(out_done_res));
          check_field("status", 16'(want.status), 16'(out_status));
          check_field("temperature_raw", want.temp, out_temperature_raw);
          if (want.done && want.status) n_no_presence++;
          if (want.done && !want.status) n_reads_ok++;
        end
      end
      // watchdog
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", quiet);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    gen_state = sequencer_reset();
    chk_state = sequencer_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one continuous stream, paced differently in each phase
    run_phase(1'b0, owts_pkg::CONV_WAIT_RST, 0, 0, PHASE_ITEMS);
    run_phase(1'b1, 20'd0, 52, 0, PHASE_ITEMS);
    run_phase(1'b1, 20'hFFFFF, 0, 52, PHASE_ITEMS);
    run_phase(1'b1, 20'($urandom_range(1, 400)), 14, 14, PHASE_ITEMS);
    repeat (10) @(negedge clk);

    $display("Run covered %0d input transfers and %0d checked results.", n_accepted, n_results);
    $display("%0d reads completed, %0d runs ended on a missing presence pulse.",
             n_reads_ok, n_no_presence);
    if (errs == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/owts_pkg.sv
rtl/core/onewire_temp_read_sequencer_unit.sv
tb/tb_top.sv
